### hdl/mcsc_pkg.sv
// ----------------------------------------------------------------------------
// mcsc_pkg: shared types and constants for the stick cutting cost engine
// Sizes, error codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcsc_pkg;

  localparam int MAX_CUTS  = 64;
  localparam int POS_WIDTH = 16;
  localparam int IN_POS_W  = 16;
  localparam int COST_W    = 24;
  localparam int ERR_W     = 2;

  localparam int NUM_ENDS  = MAX_CUTS + 2;
  localparam int IDX_W     = $clog2(NUM_ENDS);
  localparam int CNT_W     = $clog2(MAX_CUTS + 1);
  localparam int TBL_DEPTH = NUM_ENDS * NUM_ENDS;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int SUM_W     = COST_W + 1;
  localparam int TOT_W     = ((SUM_W > POS_WIDTH) ? SUM_W : POS_WIDTH) + 1;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [COST_W-1:0]    cost_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [TOT_W-1:0]     tot_t;

  localparam cost_t COST_MAX = '1;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_MANY = 2'd1,
    ERR_ORDER    = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEG,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // cut item accepted
    logic start;      // end item accepted
    logic init_step;  // clear one unit segment
    logic seg_start;  // fetch endpoints of the current segment
    logic scan_step;  // issue one split pair
    logic write_seg;  // store the segment cost
    logic finish;     // move the result to the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_err;  // end item would give an error result
    logic init_last;
    logic no_gap;     // no cuts: nothing to split
    logic k_last;
    logic seg_last;   // last segment of this gap
    logic gap_last;
    logic out_free;
  } dp_stat_t;

  function automatic addr_t cost_addr(idx_t row, idx_t col);
    return addr_t'(addr_t'(row) * addr_t'(NUM_ENDS) + addr_t'(col));
  endfunction

endpackage

### hdl/mcsc_ctrl.sv
// ----------------------------------------------------------------------------
// mcsc_ctrl: sequencer for the interval cost program
// Walks load, table clear, gap/segment/split loops and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_is_stick_end,
  input  mcsc_pkg::dp_stat_t  stat,
  output mcsc_pkg::ctrl_cmd_t cmd,
  output logic                in_stall
);

  mcsc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcsc_pkg::ST_IDLE: begin
        if (in_valid && in_is_stick_end) begin
          state_nxt = stat.start_err ? mcsc_pkg::ST_DONE : mcsc_pkg::ST_INIT;
        end
      end
      mcsc_pkg::ST_INIT: begin
        if (stat.init_last) begin
          state_nxt = stat.no_gap ? mcsc_pkg::ST_DONE : mcsc_pkg::ST_SEG;
        end
      end
      mcsc_pkg::ST_SEG: begin
        state_nxt = mcsc_pkg::ST_SCAN;
      end
      mcsc_pkg::ST_SCAN: begin
        if (stat.k_last) begin
          state_nxt = mcsc_pkg::ST_DRAIN;
        end
      end
      mcsc_pkg::ST_DRAIN: begin
        state_nxt = mcsc_pkg::ST_WRITE;
      end
      mcsc_pkg::ST_WRITE: begin
        state_nxt = (stat.seg_last && stat.gap_last) ? mcsc_pkg::ST_DONE
                                                     : mcsc_pkg::ST_SEG;
      end
      mcsc_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = mcsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      mcsc_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid && !in_is_stick_end;
        cmd.start = in_valid && in_is_stick_end;
      end
      mcsc_pkg::ST_INIT:  cmd.init_step = 1'b1;
      mcsc_pkg::ST_SEG:   cmd.seg_start = 1'b1;
      mcsc_pkg::ST_SCAN:  cmd.scan_step = 1'b1;
      mcsc_pkg::ST_DRAIN: cmd           = '0;
      mcsc_pkg::ST_WRITE: cmd.write_seg = 1'b1;
      mcsc_pkg::ST_DONE:  cmd.finish    = stat.out_free;
      default:            cmd           = '0;
    endcase
  end

endmodule

### hdl/mcsc_dp.sv
// ----------------------------------------------------------------------------
// mcsc_dp: datapath for the interval cost program
// Cut loader with error latch, endpoint and cost memories, split minimum,
// segment cost with saturation, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcsc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcsc_pkg::ctrl_cmd_t             cmd,
  output mcsc_pkg::dp_stat_t              stat,
  input  logic [mcsc_pkg::IN_POS_W-1:0]   in_position,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mcsc_pkg::COST_W-1:0]     out_min_cost,
  output logic [mcsc_pkg::ERR_W-1:0]      out_error_code
);

  // memories, no reset: only written entries are ever used
  mcsc_pkg::pos_t  ep_mem   [mcsc_pkg::NUM_ENDS];
  mcsc_pkg::cost_t cost_mem [mcsc_pkg::TBL_DEPTH];

  // control state
  mcsc_pkg::cnt_t cut_count_r, cut_count_nxt;
  mcsc_pkg::err_t err_latch_r, err_latch_nxt;
  mcsc_pkg::pos_t last_pos_r, last_pos_nxt;
  mcsc_pkg::err_t err_r, err_nxt;
  mcsc_pkg::idx_t last_r, last_nxt;
  mcsc_pkg::idx_t gap_r, gap_nxt;
  mcsc_pkg::idx_t i_r, i_nxt;
  mcsc_pkg::idx_t k_r, k_nxt;
  logic           rd_valid_r;
  logic           out_valid_r, out_valid_nxt;

  // payload
  mcsc_pkg::sum_t  best_r, best_nxt;
  mcsc_pkg::cost_t result_r, result_nxt;
  mcsc_pkg::cost_t out_cost_r, out_cost_nxt;
  mcsc_pkg::err_t  out_err_r, out_err_nxt;
  mcsc_pkg::pos_t  ep_i_r, ep_j_r;
  logic            ep_i_zero_r;
  mcsc_pkg::cost_t rd_a_r, rd_b_r;

  mcsc_pkg::pos_t  pos;
  mcsc_pkg::err_t  start_err;
  mcsc_pkg::idx_t  j_idx;
  mcsc_pkg::idx_t  ep_waddr;
  logic            ep_we;
  logic            cut_ok;
  mcsc_pkg::sum_t  pair_sum;
  mcsc_pkg::pos_t  ep_i_eff;
  mcsc_pkg::tot_t  seg_total;
  mcsc_pkg::cost_t seg_cost;
  logic            cost_we;
  mcsc_pkg::addr_t cost_waddr;
  mcsc_pkg::cost_t cost_wdata;

  assign pos   = mcsc_pkg::pos_t'(in_position);
  assign j_idx = mcsc_pkg::idx_t'(i_r + gap_r);

  always_comb begin
    if (err_latch_r != mcsc_pkg::ERR_NONE) begin
      start_err = err_latch_r;
    end else if (cut_count_r != '0 && pos <= last_pos_r) begin
      start_err = mcsc_pkg::ERR_ORDER;
    end else begin
      start_err = mcsc_pkg::ERR_NONE;
    end
  end

  assign cut_ok   = (cut_count_r != mcsc_pkg::cnt_t'(mcsc_pkg::MAX_CUTS)) &&
                    (pos > last_pos_r);
  assign ep_waddr = mcsc_pkg::idx_t'(mcsc_pkg::idx_t'(cut_count_r) + mcsc_pkg::idx_t'(1));
  assign ep_we    = (cmd.load && cut_ok) ||
                    (cmd.start && start_err == mcsc_pkg::ERR_NONE);

  // endpoint 0 is never stored; it reads as zero
  assign ep_i_eff  = ep_i_zero_r ? '0 : ep_i_r;
  assign pair_sum  = mcsc_pkg::sum_t'(rd_a_r) + mcsc_pkg::sum_t'(rd_b_r);
  assign seg_total = mcsc_pkg::tot_t'(best_r) + mcsc_pkg::tot_t'(ep_j_r - ep_i_eff);
  assign seg_cost  = (seg_total > mcsc_pkg::tot_t'(mcsc_pkg::COST_MAX)) ?
                     mcsc_pkg::COST_MAX : mcsc_pkg::cost_t'(seg_total);

  assign cost_we    = cmd.init_step || cmd.write_seg;
  assign cost_waddr = cmd.init_step ?
                      mcsc_pkg::cost_addr(i_r, mcsc_pkg::idx_t'(i_r + mcsc_pkg::idx_t'(1))) :
                      mcsc_pkg::cost_addr(i_r, j_idx);
  assign cost_wdata = cmd.init_step ? '0 : seg_cost;

  always_ff @(posedge clk) begin
    if (ep_we) begin
      ep_mem[ep_waddr] <= pos;
    end
    if (cmd.seg_start) begin
      ep_i_r      <= ep_mem[i_r];
      ep_j_r      <= ep_mem[j_idx];
      ep_i_zero_r <= (i_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    if (cmd.scan_step) begin
      rd_a_r <= cost_mem[mcsc_pkg::cost_addr(i_r, k_r)];
      rd_b_r <= cost_mem[mcsc_pkg::cost_addr(k_r, j_idx)];
    end
  end

  always_comb begin
    cut_count_nxt = cut_count_r;
    err_latch_nxt = err_latch_r;
    last_pos_nxt  = last_pos_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    gap_nxt       = gap_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r;
    out_cost_nxt  = out_cost_r;
    out_err_nxt   = out_err_r;

    if (cmd.load) begin
      if (cut_ok) begin
        cut_count_nxt = mcsc_pkg::cnt_t'(cut_count_r + mcsc_pkg::cnt_t'(1));
        last_pos_nxt  = pos;
      end else if (err_latch_r == mcsc_pkg::ERR_NONE) begin
        err_latch_nxt = (cut_count_r == mcsc_pkg::cnt_t'(mcsc_pkg::MAX_CUTS)) ?
                        mcsc_pkg::ERR_TOO_MANY : mcsc_pkg::ERR_ORDER;
      end
    end

    if (cmd.start) begin
      err_nxt       = start_err;
      last_nxt      = ep_waddr;
      cut_count_nxt = '0;
      err_latch_nxt = mcsc_pkg::ERR_NONE;
      last_pos_nxt  = '0;
      i_nxt         = '0;
      result_nxt    = '0;
    end

    if (cmd.init_step) begin
      if (stat.init_last) begin
        i_nxt   = '0;
        gap_nxt = mcsc_pkg::idx_t'(2);
      end else begin
        i_nxt = mcsc_pkg::idx_t'(i_r + mcsc_pkg::idx_t'(1));
      end
    end

    if (cmd.seg_start) begin
      k_nxt    = mcsc_pkg::idx_t'(i_r + mcsc_pkg::idx_t'(1));
      best_nxt = '1;
    end

    if (cmd.scan_step) begin
      k_nxt = mcsc_pkg::idx_t'(k_r + mcsc_pkg::idx_t'(1));
    end

    // split pair data arrives in the cycle after its read
    if (rd_valid_r && pair_sum < best_r) begin
      best_nxt = pair_sum;
    end

    if (cmd.write_seg) begin
      result_nxt = seg_cost;
      if (stat.seg_last) begin
        i_nxt   = '0;
        gap_nxt = mcsc_pkg::idx_t'(gap_r + mcsc_pkg::idx_t'(1));
      end else begin
        i_nxt = mcsc_pkg::idx_t'(i_r + mcsc_pkg::idx_t'(1));
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_cost_nxt  = result_r;
      out_err_nxt   = err_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_count_r <= '0;
      err_latch_r <= mcsc_pkg::ERR_NONE;
      last_pos_r  <= '0;
      err_r       <= mcsc_pkg::ERR_NONE;
      last_r      <= '0;
      gap_r       <= '0;
      i_r         <= '0;
      k_r         <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cut_count_r <= cut_count_nxt;
      err_latch_r <= err_latch_nxt;
      last_pos_r  <= last_pos_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      gap_r       <= gap_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      rd_valid_r  <= cmd.scan_step;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    result_r   <= result_nxt;
    out_cost_r <= out_cost_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_comb begin
    stat.start_err = (start_err != mcsc_pkg::ERR_NONE);
    stat.init_last = (mcsc_pkg::idx_t'(i_r + mcsc_pkg::idx_t'(1)) == last_r);
    stat.no_gap    = (last_r == mcsc_pkg::idx_t'(1));
    stat.k_last    = (mcsc_pkg::idx_t'(k_r + mcsc_pkg::idx_t'(1)) == j_idx);
    stat.seg_last  = (j_idx == last_r);
    stat.gap_last  = (gap_r == last_r);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_min_cost   = out_cost_r;
  assign out_error_code = out_err_r;

endmodule

### hdl/min_cost_stick_cutting.sv
// ----------------------------------------------------------------------------
// min_cost_stick_cutting: minimum total cost of cutting a stick
// Cut item: accepted while idle, no result. End item with n cuts: the run time
//   is set by the one split pair read from the cost memory per cycle in the
//   split scan. Error results and n = 0 skip the split loops.
// Reset: synchronous, active low, clears control; memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_cost_stick_cutting (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mcsc_pkg::IN_POS_W-1:0] in_position,
  input  logic                          in_is_stick_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcsc_pkg::COST_W-1:0]   out_min_cost,
  output logic [mcsc_pkg::ERR_W-1:0]    out_error_code
);

  mcsc_pkg::ctrl_cmd_t cmd;
  mcsc_pkg::dp_stat_t  stat;

  mcsc_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_is_stick_end (in_is_stick_end),
    .stat            (stat),
    .cmd             (cmd),
    .in_stall        (in_stall)
  );

  mcsc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_min_cost   (out_min_cost),
    .out_error_code (out_error_code)
  );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the stick cutting cost engine
// Feeds cut positions and stick lengths under varied idle and stall patterns.
// A scoreboard predicts each min_cost/error_code pair with its own interval DP
// and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mcsc_pkg::*;

  localparam int ITEM_TARGET = 550;
  localparam int QUIET_LIMIT = 250000;

  class cut_cost_scoreboard;
    int unsigned loaded = 0;
    err_t        latch  = ERR_NONE;
    pos_t        ends[NUM_ENDS];
    cost_t       want_cost[$];
    err_t        want_err[$];
    int          mismatches = 0;

    function int pending();
      return want_cost.size();
    endfunction

    function cost_t cheapest_cutting_cost(int n_ends);
      cost_t  tbl[NUM_ENDS][NUM_ENDS];
      longint best, sum, total;
      int     j;
      for (int i = 0; i + 1 < n_ends; i++) tbl[i][i+1] = '0;
      for (int gap = 2; gap < n_ends; gap++) begin
        for (int i = 0; i + gap < n_ends; i++) begin
          j = i + gap;
          best = 64'sh7fff_ffff_ffff_ffff;
          for (int k = i + 1; k < j; k++) begin
            sum = longint'(tbl[i][k]) + longint'(tbl[k][j]);
            if (sum < best) best = sum;
          end
          total = best + longint'(ends[j]) - longint'(ends[i]);
          tbl[i][j] = (total > longint'(COST_MAX)) ? COST_MAX : cost_t'(total);
        end
      end
      return tbl[0][n_ends-1];
    endfunction

    function void note_item(pos_t p, logic is_end);
      err_t  e;
      cost_t c;
      ends[0] = '0;
      if (!is_end) begin
        if (loaded >= MAX_CUTS) begin
          if (latch == ERR_NONE) latch = ERR_TOO_MANY;
        end else if (p <= ends[loaded]) begin
          if (latch == ERR_NONE) latch = ERR_ORDER;
        end else begin
          loaded++;
          ends[loaded] = p;
        end
        return;
      end
      e = latch;
      c = '0;
      if (e == ERR_NONE && loaded > 0 && p <= ends[loaded]) e = ERR_ORDER;
      if (e == ERR_NONE) begin
        ends[loaded+1] = p;
        c = cheapest_cutting_cost(loaded + 2);
      end
      want_cost.push_back(c);
      want_err.push_back(e);
      loaded = 0;
      latch  = ERR_NONE;
    endfunction

    function void check_result(cost_t c, logic [ERR_W-1:0] e);
      cost_t xc;
      err_t  xe;
      if (want_cost.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: min_cost=%0d error_code=%0d", c, e);
        return;
      end
      xc = want_cost.pop_front();
      xe = want_err.pop_front();
      if (c !== xc || e !== xe) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: min_cost exp %0d got %0d, error_code exp %0d got %0d",
                   xc, c, xe, e);
      end
    endfunction
  endclass

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [IN_POS_W-1:0] in_position     = '0;
  logic                in_is_stick_end = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [COST_W-1:0]   out_min_cost;
  logic [ERR_W-1:0]    out_error_code;

  cut_cost_scoreboard sb;
  int unsigned        idle_pct  = 0;
  int unsigned        stall_pct = 0;
  int                 items_sent = 0;
  int                 quiet_cycles = 0;

  min_cost_stick_cutting dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_position     (in_position),
    .in_is_stick_end (in_is_stick_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_min_cost    (out_min_cost),
    .out_error_code  (out_error_code)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // accepted items, results and the watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_item(pos_t'(in_position), in_is_stick_end);
      if (out_valid && !out_stall) sb.check_result(out_min_cost, out_error_code);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("** min_cost_stick_cutting: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input int unsigned p, input bit is_end);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_position     <= p[IN_POS_W-1:0];
    in_is_stick_end <= is_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender off until every pending result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // n increasing cuts below len; optional bad cut before cut bad_at,
  // optional stick length not above the last cut
  task automatic send_stick(input int n, input int unsigned len, input int bad_at,
                            input bit bad_len);
    int unsigned prev;
    int unsigned room;
    prev = 0;
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) send_item((prev == 0) ? 0 : $urandom_range(0, prev), 1'b0);
      room = len - (n - i) - prev;
      prev = prev + 1 + $urandom_range(0, (room - 1) / (n - i));
      send_item(prev, 1'b0);
    end
    if (bad_at >= n) send_item($urandom_range(0, prev), 1'b0);
    send_item(bad_len ? $urandom_range(0, prev) : len, 1'b1);
  endtask

  initial begin
    int          phase;
    int          next_phase;
    int          stick_no;
    int          kind;
    int          n;
    int unsigned len;
    int          too_many_done;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sticks
    send_item(0, 1'b1);                                    // no cuts, zero length
    send_item(16'hffff, 1'b1);                             // no cuts, full length
    send_item(1, 1'b0); send_item(16'hffff, 1'b1);
    send_item(16'hffff, 1'b0); send_item(16'hffff, 1'b1);  // cut not below length
    send_item(0, 1'b0); send_item(10, 1'b1);               // cut at zero
    send_item(100, 1'b0); send_item(100, 1'b0);            // repeat, then a drop
    send_item(50, 1'b0); send_item(200, 1'b1);
    send_item(3, 1'b0); send_item(7, 1'b0); send_item(9, 1'b0);
    send_item(10, 1'b1);
    send_item(5, 1'b0); send_item(3, 1'b1);                // length below last cut
    send_item(16'h8000, 1'b0); send_item(16'hfffe, 1'b0);
    send_item(16'hffff, 1'b1);

    phase = 0;
    stick_no = 0;
    too_many_done = 0;
    while (items_sent < ITEM_TARGET) begin
      next_phase = items_sent * 4 / ITEM_TARGET;
      if (next_phase != phase) begin
        drain_results();
        phase = next_phase;
        idle_pct  = (phase == 1) ? 85 : (phase == 3) ? 6 : 0;
        stall_pct = (phase == 2) ? 85 : (phase == 3) ? 6 : 0;
      end
      kind = $urandom_range(0, 99);
      if (stick_no == 9 || stick_no == 47) begin
        // full set of cuts: the slowest case
        send_stick(MAX_CUTS, $urandom_range(MAX_CUTS + 1, 65535), -1, 1'b0);
      end else if (stick_no == 20 || stick_no == 60 ||
                   (kind < 2 && too_many_done < 3)) begin
        too_many_done++;
        if ($urandom_range(0, 1)) send_item(0, 1'b0);      // order error first
        for (int i = 0; i < MAX_CUTS + $urandom_range(1, 3); i++)
          send_item(i + 1 + $urandom_range(0, 1) * 100 * i, 1'b0);
        send_item($urandom_range(MAX_CUTS * 101, 65535), 1'b1);
      end else if (kind < 70) begin
        n = (kind < 10) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        len = $urandom_range(0, 1) ? $urandom_range(n + 1, n + 40)
                                   : $urandom_range(n + 1, 65535);
        if (kind >= 58 && n > 0) send_stick(n, len, $urandom_range(0, n), 1'b0);
        else if (kind >= 48 && n > 0) send_stick(n, len, -1, 1'b1);
        else send_stick(n, len, -1, 1'b0);
      end else if (kind < 85) begin
        n = $urandom_range(1, 6);
        send_stick(n, $urandom_range(n + 1, 65535), $urandom_range(0, n), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(0, 65535), ($urandom_range(0, 3) == 0));
        send_item($urandom_range(0, 65535), 1'b1);
      end
      stick_no++;
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** min_cost_stick_cutting: PASSED **");
    end else begin
      if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
      $display("** min_cost_stick_cutting: FAILED **");
    end
    $finish;
  end

endmodule
